@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker module of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle, off during reset.
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Condition implies consequence in the next cycle, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

// Condition implies consequence in the next cycle, checked during reset too.
`define ASSERT_NEXT_ALWAYS(label, clk, cond, cons) \
    label: assert property (@(posedge clk) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/tlpfk_pkg.sv @@
// Types, constants and the CORDIC arctangent table of the two-link arm block.
// No dependencies.
package tlpfk_pkg;

    localparam int TRIG_STAGES    = 16;
    localparam int ATAN_ENTRIES   = 24;
    localparam int CORDIC_STAGES  = (TRIG_STAGES < ATAN_ENTRIES) ? TRIG_STAGES : ATAN_ENTRIES;
    localparam int TURN_UNITS     = 46080;
    localparam int HALF_TURN      = 23040;
    localparam int QUARTER_TURN   = 11520;
    localparam int ANGLE_SHIFT    = 13;
    localparam int CORDIC_GAIN    = 652032874;
    localparam int TRIG_ONE       = 65536;
    localparam int TRIG_FRAC_DROP = 14;
    localparam int POS_FRAC_DROP  = 16;

    typedef logic signed [16:0] angle_t;
    typedef logic signed [18:0] wang_t;
    typedef logic signed [15:0] hang_t;
    typedef logic signed [28:0] zang_t;
    typedef logic signed [31:0] cordic_t;
    typedef logic signed [17:0] trig_t;
    typedef logic signed [34:0] prod_t;
    typedef logic signed [17:0] pos_t;
    typedef logic        [15:0] len_t;
    typedef logic        [1:0]  cfg_index_t;

    localparam cfg_index_t CFG_BASE_LEN  = 2'd0;
    localparam cfg_index_t CFG_ELBOW_LEN = 2'd1;

    // Arctangent of 2^-idx in units of 2^-20 degree.
    function automatic zang_t atan_q20(input int unsigned idx);
        zang_t v;
        case (idx)
            0:  v = 29'sd47185920;
            1:  v = 29'sd27855475;
            2:  v = 29'sd14718068;
            3:  v = 29'sd7471121;
            4:  v = 29'sd3750058;
            5:  v = 29'sd1876857;
            6:  v = 29'sd938658;
            7:  v = 29'sd469357;
            8:  v = 29'sd234682;
            9:  v = 29'sd117342;
            10: v = 29'sd58671;
            11: v = 29'sd29335;
            12: v = 29'sd14668;
            13: v = 29'sd7334;
            14: v = 29'sd3667;
            15: v = 29'sd1833;
            16: v = 29'sd917;
            17: v = 29'sd458;
            18: v = 29'sd229;
            19: v = 29'sd115;
            20: v = 29'sd57;
            21: v = 29'sd29;
            22: v = 29'sd14;
            23: v = 29'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/two_link_planar_forward_kinematics.sv @@
// Forward kinematics of a two-link planar arm on a pipelined CORDIC datapath.
// Depends on tlpfk_pkg.
//
// Usage: the input channel (s_valid/s_ready) carries a base and an elbow
// joint angle in signed 1/128 degree. The result channel (m_valid/m_ready)
// returns the tool tip x and y in signed Q10.8 mm for Q8.8 mm lengths,
// one result item per input item, in order. The two link lengths are
// written over the configuration channel (cfg_valid/cfg_ready, index 0
// base, 1 elbow) while the block is idle; cfg_ready is always high.
// Pipeline: an accepted input item passes through the input, turn reduction,
// quadrant fold, one per CORDIC stage, rounding, multiply and sum registers
// before its result item is offered. Throughput is one item per cycle while
// the receiver takes results, set by the two CORDIC lanes that run side by
// side, one for each angle.
// Reset clears all valid bits and both link lengths. When the receiver
// stalls, the result holds in the output register and each stage keeps
// accepting until the stage after it is full, so empty slots fill up
// before s_ready drops.
module two_link_planar_forward_kinematics (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tlpfk_pkg::angle_t      s_base_angle,
    input  tlpfk_pkg::angle_t      s_elbow_angle,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tlpfk_pkg::pos_t        m_tip_x,
    output tlpfk_pkg::pos_t        m_tip_y,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  tlpfk_pkg::cfg_index_t  cfg_index,
    input  tlpfk_pkg::len_t        cfg_data
);
    import tlpfk_pkg::*;

    localparam int ST_IN      = 0;
    localparam int ST_RED     = 1;
    localparam int ST_FOLD    = 2;
    localparam int ST_CORDIC0 = 3;
    localparam int ST_ROUND   = CORDIC_STAGES + 3;
    localparam int ST_MULT    = CORDIC_STAGES + 4;
    localparam int ST_OUT     = CORDIC_STAGES + 5;
    localparam int NUM_STAGES = CORDIC_STAGES + 6;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES:0]   rdy;

    len_t    base_len_reg;
    len_t    elbow_len_reg;

    wang_t   ang_reg [2];
    hang_t   red_reg [2];
    cordic_t x_reg   [CORDIC_STAGES+1][2];
    cordic_t y_reg   [CORDIC_STAGES+1][2];
    zang_t   z_reg   [CORDIC_STAGES+1][2];
    logic    flip_reg [CORDIC_STAGES+1][2];
    trig_t   cos_reg [2];
    trig_t   sin_reg [2];
    prod_t   px_reg  [2];
    prod_t   py_reg  [2];
    pos_t    tip_x_reg;
    pos_t    tip_y_reg;

    function automatic hang_t reduce_turn(input wang_t v);
        wang_t r;
        priority if (v >= wang_t'(2 * TURN_UNITS + HALF_TURN)) begin
            r = wang_t'(v - 3 * TURN_UNITS);
        end else if (v >= wang_t'(TURN_UNITS + HALF_TURN)) begin
            r = wang_t'(v - 2 * TURN_UNITS);
        end else if (v >= wang_t'(HALF_TURN)) begin
            r = wang_t'(v - TURN_UNITS);
        end else if (v >= wang_t'(-HALF_TURN)) begin
            r = v;
        end else if (v >= wang_t'(-TURN_UNITS - HALF_TURN)) begin
            r = wang_t'(v + TURN_UNITS);
        end else if (v >= wang_t'(-2 * TURN_UNITS - HALF_TURN)) begin
            r = wang_t'(v + 2 * TURN_UNITS);
        end else begin
            r = wang_t'(v + 3 * TURN_UNITS);
        end
        return r[15:0];
    endfunction

    assign rdy[NUM_STAGES] = m_ready;
    genvar gi;
    generate
        for (gi = 0; gi < NUM_STAGES; gi++) begin : g_rdy
            assign rdy[gi] = !vld_reg[gi] || rdy[gi+1];
        end
    endgenerate

    assign s_ready   = rdy[ST_IN];
    assign m_valid   = vld_reg[ST_OUT];
    assign m_tip_x   = tip_x_reg;
    assign m_tip_y   = tip_y_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= (i == 0) ? s_valid : vld_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_len_reg  <= '0;
            elbow_len_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BASE_LEN:  base_len_reg  <= cfg_data;
                CFG_ELBOW_LEN: elbow_len_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[ST_IN]) begin
            ang_reg[0] <= wang_t'(s_base_angle);
            ang_reg[1] <= wang_t'(s_base_angle) + wang_t'(s_elbow_angle);
        end
        if (rdy[ST_RED]) begin
            for (int l = 0; l < 2; l++) begin
                red_reg[l] <= reduce_turn(ang_reg[l]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        hang_t q;
        logic  f;
        if (rdy[ST_FOLD]) begin
            for (int l = 0; l < 2; l++) begin
                priority if (red_reg[l] > hang_t'(QUARTER_TURN)) begin
                    q = red_reg[l] - hang_t'(HALF_TURN);
                    f = 1'b1;
                end else if (red_reg[l] < hang_t'(-QUARTER_TURN)) begin
                    q = red_reg[l] + hang_t'(HALF_TURN);
                    f = 1'b1;
                end else begin
                    q = red_reg[l];
                    f = 1'b0;
                end
                x_reg[0][l]    <= cordic_t'(CORDIC_GAIN);
                y_reg[0][l]    <= '0;
                z_reg[0][l]    <= zang_t'(q) <<< ANGLE_SHIFT;
                flip_reg[0][l] <= f;
            end
        end
    end

    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
            always_ff @(posedge aclk) begin
                if (rdy[ST_CORDIC0 + gi]) begin
                    for (int l = 0; l < 2; l++) begin
                        if (z_reg[gi][l] >= 0) begin
                            x_reg[gi+1][l] <= x_reg[gi][l] - (y_reg[gi][l] >>> gi);
                            y_reg[gi+1][l] <= y_reg[gi][l] + (x_reg[gi][l] >>> gi);
                            z_reg[gi+1][l] <= z_reg[gi][l] - atan_q20(gi);
                        end else begin
                            x_reg[gi+1][l] <= x_reg[gi][l] + (y_reg[gi][l] >>> gi);
                            y_reg[gi+1][l] <= y_reg[gi][l] - (x_reg[gi][l] >>> gi);
                            z_reg[gi+1][l] <= z_reg[gi][l] + atan_q20(gi);
                        end
                        flip_reg[gi+1][l] <= flip_reg[gi][l];
                    end
                end
            end
        end
    endgenerate

    function automatic trig_t round_trig(input cordic_t v, input logic flip);
        cordic_t w;
        trig_t   t;
        w = (v + cordic_t'(1 << (TRIG_FRAC_DROP - 1))) >>> TRIG_FRAC_DROP;
        if (w > cordic_t'(TRIG_ONE)) begin
            t = trig_t'(TRIG_ONE);
        end else if (w < cordic_t'(-TRIG_ONE)) begin
            t = trig_t'(-TRIG_ONE);
        end else begin
            t = w[17:0];
        end
        return flip ? -t : t;
    endfunction

    always_ff @(posedge aclk) begin
        if (rdy[ST_ROUND]) begin
            for (int l = 0; l < 2; l++) begin
                cos_reg[l] <= round_trig(x_reg[CORDIC_STAGES][l], flip_reg[CORDIC_STAGES][l]);
                sin_reg[l] <= round_trig(y_reg[CORDIC_STAGES][l], flip_reg[CORDIC_STAGES][l]);
            end
        end
        if (rdy[ST_MULT]) begin
            px_reg[0] <= prod_t'(signed'({1'b0, base_len_reg})) * prod_t'(cos_reg[0]);
            py_reg[0] <= prod_t'(signed'({1'b0, base_len_reg})) * prod_t'(sin_reg[0]);
            px_reg[1] <= prod_t'(signed'({1'b0, elbow_len_reg})) * prod_t'(cos_reg[1]);
            py_reg[1] <= prod_t'(signed'({1'b0, elbow_len_reg})) * prod_t'(sin_reg[1]);
        end
    end

    prod_t sum_x;
    prod_t sum_y;
    assign sum_x = px_reg[0] + px_reg[1] + prod_t'(1 << (POS_FRAC_DROP - 1));
    assign sum_y = py_reg[0] + py_reg[1] + prod_t'(1 << (POS_FRAC_DROP - 1));

    always_ff @(posedge aclk) begin
        if (rdy[ST_OUT]) begin
            tip_x_reg <= sum_x[33:16];
            tip_y_reg <= sum_y[33:16];
        end
    end

endmodule

@@ hdl/tlpfk_checker.sv @@
// Port-level checker for the two-link arm block, bound to its top level.
// Depends on tlpfk_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlpfk_checker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_ready,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  tlpfk_pkg::pos_t        m_tip_x,
    input  tlpfk_pkg::pos_t        m_tip_y
);

    // A result item that is not taken stays offered.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

    // A result item that is not taken keeps its payload.
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_valid && !m_ready, $stable({m_tip_x, m_tip_y}))

    // The input side only backs up when a result item is waiting.
    `ASSERT_SAME(a_backpressure, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // Reset empties the pipeline.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule

bind two_link_planar_forward_kinematics tlpfk_checker u_tlpfk_checker (.*);

@@ sim/two_link_planar_forward_kinematics_tb.sv @@
// Self-checking testbench for the two-link planar arm forward kinematics block.
// Uses tlpfk_pkg for port types and constants; drives a directed table, then random items.
// Each tip position is checked against an in-bench CORDIC predictor, or against the table values for typed entries.
`timescale 1ns / 100ps

module two_link_planar_forward_kinematics_tb;

    import tlpfk_pkg::*;

    localparam cfg_index_t CFG_SPARE_LO = 2'd2;
    localparam cfg_index_t CFG_SPARE_HI = 2'd3;
    localparam int ITEMS_PER_BLOCK = 200;
    localparam int LONG_HOLD_CYCLES = 400;

    localparam longint ARCTAN_Q20 [ATAN_ENTRIES] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

    typedef struct {
        step_kind_t kind;
        cfg_index_t idx;
        int         data;
        int         a1;
        int         a2;
        bit         typed;
        int         x;
        int         y;
    } step_t;

    typedef struct {
        pos_t x;
        pos_t y;
    } tip_t;

    localparam int DIRECTED_STEPS = 29;

    step_t directed_steps [DIRECTED_STEPS] = '{
        '{STEP_ITEM, CFG_BASE_LEN, 0, 0, 0, 1'b1, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 46080, 46080, 1'b1, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, -46080, -46080, 1'b1, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, -65536, 65535, 1'b1, 0, 0},
        '{STEP_CFG, CFG_BASE_LEN, 16'h0100, 0, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 0, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 11520, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, -11520, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 11521, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, -11521, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 23040, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, -23040, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 23039, 0, 1'b0, 0, 0},
        '{STEP_CFG, CFG_BASE_LEN, 16'hFFFF, 0, 0, 1'b0, 0, 0},
        '{STEP_CFG, CFG_ELBOW_LEN, 16'hFFFF, 0, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 0, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 5760, 5760, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 0, 23040, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, -46080, 46080, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 65535, 65535, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, -65536, -65536, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 46080, -1, 1'b0, 0, 0},
        '{STEP_CFG, CFG_BASE_LEN, 16'h0000, 0, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 3000, -7000, 1'b0, 0, 0},
        '{STEP_CFG, CFG_SPARE_LO, 16'h1234, 0, 0, 1'b0, 0, 0},
        '{STEP_CFG, CFG_SPARE_HI, 16'hABCD, 0, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, 1000, 2000, 1'b0, 0, 0},
        '{STEP_CFG, CFG_BASE_LEN, 16'h2A5F, 0, 0, 1'b0, 0, 0},
        '{STEP_ITEM, CFG_BASE_LEN, 0, -30000, 12345, 1'b0, 0, 0}
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    angle_t     s_base_angle = '0;
    angle_t     s_elbow_angle = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    pos_t       m_tip_x;
    pos_t       m_tip_y;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = CFG_BASE_LEN;
    len_t       cfg_data = '0;

    len_t base_len = '0;
    len_t elbow_len = '0;
    tip_t pending_tips [$];
    tip_t got_tip;
    tip_t want_tip;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   hold_req = 1'b0;
    int   hold_left = 0;
    int   mismatches = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    int   length_writes = 0;

    two_link_planar_forward_kinematics dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base_angle  (s_base_angle),
        .s_elbow_angle (s_elbow_angle),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tip_x       (m_tip_x),
        .m_tip_y       (m_tip_y),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic longint round_trig(input longint v);
        longint r;
        r = (v + (longint'(1) <<< (TRIG_FRAC_DROP - 1))) >>> TRIG_FRAC_DROP;
        if (r > TRIG_ONE)
            r = TRIG_ONE;
        if (r < -TRIG_ONE)
            r = -TRIG_ONE;
        return r;
    endfunction

    task automatic unit_vector(input longint angle, output longint cs, output longint sn);
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        r = angle % TURN_UNITS;
        if (r < 0)
            r += TURN_UNITS;
        if (r >= HALF_TURN)
            r -= TURN_UNITS;
        flip = 1'b0;
        if (r > QUARTER_TURN) begin
            r -= HALF_TURN;
            flip = 1'b1;
        end else if (r < -QUARTER_TURN) begin
            r += HALF_TURN;
            flip = 1'b1;
        end
        z = r * (longint'(1) <<< ANGLE_SHIFT);
        x = CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ARCTAN_Q20[i];
            end else begin
                x += dx;
                y -= dy;
                z += ARCTAN_Q20[i];
            end
        end
        cs = round_trig(x);
        sn = round_trig(y);
        if (flip) begin
            cs = -cs;
            sn = -sn;
        end
    endtask

    task automatic predict_tip(input angle_t a1, input angle_t a2, output tip_t t);
        longint c1;
        longint s1;
        longint c12;
        longint s12;
        longint l1;
        longint l2;
        longint half;
        unit_vector(longint'(a1), c1, s1);
        unit_vector(longint'(a1) + longint'(a2), c12, s12);
        l1 = base_len;
        l2 = elbow_len;
        half = longint'(1) <<< (POS_FRAC_DROP - 1);
        t.x = pos_t'((l1 * c1 + l2 * c12 + half) >>> POS_FRAC_DROP);
        t.y = pos_t'((l1 * s1 + l2 * s12 + half) >>> POS_FRAC_DROP);
    endtask

    function automatic angle_t rand_angle();
        int k;
        unique case ($urandom_range(9))
            0: return angle_t'($urandom_range(131071));
            1: begin
                k = $urandom_range(8);
                return angle_t'((k - 4) * QUARTER_TURN + int'($urandom_range(4)) - 2);
            end
            2: return angle_t'(int'($urandom_range(128)) - 64);
            default: return angle_t'(int'($urandom_range(2 * TURN_UNITS)) - TURN_UNITS);
        endcase
    endfunction

    function automatic len_t rand_length();
        unique case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return len_t'($urandom);
        endcase
    endfunction

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_tips.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_length(input cfg_index_t idx, input len_t value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (idx == CFG_BASE_LEN)
            base_len = value;
        else if (idx == CFG_ELBOW_LEN)
            elbow_len = value;
        length_writes++;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(input angle_t a1, input angle_t a2, input bit typed,
                             input pos_t tx, input pos_t ty);
        tip_t want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_base_angle <= a1;
        s_elbow_angle <= a2;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (typed) begin
            want.x = tx;
            want.y = ty;
        end else begin
            predict_tip(a1, a2, want);
        end
        pending_tips.push_back(want);
        items_sent++;
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got_tip.x = m_tip_x;
                got_tip.y = m_tip_y;
                if (pending_tips.size() == 0) begin
                    report_mismatch("result with nothing pending, tip_x", got_tip.x, 0);
                end else begin
                    want_tip = pending_tips.pop_front();
                    if (got_tip.x !== want_tip.x)
                        report_mismatch("tip_x", got_tip.x, want_tip.x);
                    if (got_tip.y !== want_tip.y)
                        report_mismatch("tip_y", got_tip.y, want_tip.y);
                end
                results_seen++;
            end
            if (hold_req && hold_left == 0) begin
                hold_left = LONG_HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 30;
        recv_idle_pct = 52;
        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_CFG)
                write_length(directed_steps[i].idx, len_t'(directed_steps[i].data));
            else
                send_item(angle_t'(directed_steps[i].a1), angle_t'(directed_steps[i].a2),
                          directed_steps[i].typed, pos_t'(directed_steps[i].x),
                          pos_t'(directed_steps[i].y));
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 52 : 0;
            recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 30 : 0;
            for (int blk = 0; blk < 3; blk++) begin
                write_length(CFG_BASE_LEN, rand_length());
                write_length(CFG_ELBOW_LEN, rand_length());
                if ($urandom_range(1))
                    write_length($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                                 len_t'($urandom));
                if (phase == 2 && blk == 0)
                    hold_req = 1'b1;
                for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
                    if (phase == 0 && blk == 1 && n == ITEMS_PER_BLOCK / 2)
                        settle();
                    send_item(rand_angle(), rand_angle(), 1'b0, '0, '0);
                end
            end
        end

        settle();
        repeat (3 * (CORDIC_STAGES + 6)) @(posedge aclk);
        if (pending_tips.size() != 0)
            report_mismatch("results still pending at end", pending_tips.size(), 0);

        $display("Sent %0d joint-angle items, checked %0d tip positions, %0d length writes.",
                 items_sent, results_seen, length_writes);
        $display("Ran with sender and receiver idling, a long output stall and no idling.");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
